>>> rtl/irht_pkg.sv
package irht_pkg;

  localparam int COORD_BITS  = 24;
  localparam int TARGET_BITS = 16;
  localparam int DIFF_BITS   = COORD_BITS + 1;
  localparam int PROD_BITS   = 2 * DIFF_BITS;
  localparam int SUM_BITS    = PROD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;
  typedef logic [TARGET_BITS-1:0]       id_t;

  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_DEFAULT = 3'd1,
    KIND_RECT    = 3'd2,
    KIND_CIRCLE  = 3'd3,
    KIND_VERTEX  = 3'd4,
    KIND_CLOSE   = 3'd5,
    KIND_FINISH  = 3'd6
  } kind_t;

  // front end -> multiplier stage
  typedef struct packed {
    logic   valid;
    kind_t  kind;
    id_t    id;
    logic   rect_hit;
    logic   circ_ok;
    logic   close_live;
    logic   forced;
    logic   edge_toggle;
    logic   edge_mul;
    diff_t  op_a;
    diff_t  op_b;
    diff_t  op_c;
    diff_t  op_d;
    coord_t radius;
  } fe_t;

  // multiplier stage -> decision stage
  typedef struct packed {
    logic  valid;
    kind_t kind;
    id_t   id;
    logic  rect_hit;
    logic  circ_ok;
    logic  close_live;
    logic  forced;
    logic  edge_toggle;
    logic  edge_mul;
    prod_t p0;
    prod_t p1;
    prod_t rsq;
  } mp_t;

endpackage

>>> rtl/image_region_hit_test_core.sv
// Throughput: one record per cycle unless stalled; a pipeline of input register,
// front-end register, multiplier register and decision/output register, with the
// multiplies feeding the multiplier register. The pipe halts only when a finish
// reaches the multiplier register while the result is stalled.
// Reset: synchronous active-low rst_n clears the query point, the polygon and
// match state and all valid flags; no result is pending after reset.
module image_region_hit_test_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_kind,
  input  irht_pkg::coord_t in_a_x,
  input  irht_pkg::coord_t in_a_y,
  input  irht_pkg::coord_t in_b_x,
  input  irht_pkg::coord_t in_b_y,
  input  irht_pkg::id_t    in_target_id,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_found,
  output irht_pkg::id_t    out_match_id
);

  irht_pkg::fe_t fe_r;
  irht_pkg::mp_t mp_r;
  logic          en;

  // a finish in the last stage cannot move while the output transfer is stalled
  assign en = !(out_valid && out_stall && mp_r.valid && mp_r.kind == irht_pkg::KIND_FINISH);
  assign in_stall = !en;

  irht_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .in_valid     (in_valid),
    .in_kind      (in_kind),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_target_id (in_target_id),
    .fe_r         (fe_r)
  );

  irht_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .fe_r  (fe_r),
    .mp_r  (mp_r)
  );

  irht_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .en           (en),
    .mp_r         (mp_r),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .out_found    (out_found),
    .out_match_id (out_match_id)
  );

endmodule

>>> rtl/irht_front.sv
module irht_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [2:0]            in_kind,
  input  irht_pkg::coord_t      in_a_x,
  input  irht_pkg::coord_t      in_a_y,
  input  irht_pkg::coord_t      in_b_x,
  input  irht_pkg::coord_t      in_b_y,
  input  irht_pkg::id_t         in_target_id,
  output irht_pkg::fe_t         fe_r
);

  logic              in_v_r;
  irht_pkg::kind_t   kind_r;
  irht_pkg::coord_t  ax_r, ay_r, bx_r, by_r;
  irht_pkg::id_t     id_r;

  irht_pkg::coord_t  point_x_r, point_y_r, first_vx_r, first_vy_r, prev_vx_r, prev_vy_r;
  irht_pkg::coord_t  point_x_nxt, point_y_nxt, first_vx_nxt, first_vy_nxt;
  irht_pkg::coord_t  prev_vx_nxt, prev_vy_nxt;
  logic              vertex_seen_r, vertex_seen_nxt, edge_forced_r, edge_forced_nxt;

  irht_pkg::fe_t     fe_nxt;

  irht_pkg::diff_t   px, py, ax, ay, bx, by, x1, y1, x2, y2, dy, ty;
  logic              span, right_all, left_all, edge_active, force_set, on_h;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (en) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      kind_r <= irht_pkg::kind_t'(in_kind);
      ax_r   <= in_a_x;
      ay_r   <= in_a_y;
      bx_r   <= in_b_x;
      by_r   <= in_b_y;
      id_r   <= in_target_id;
    end
  end

  always_comb begin
    px = irht_pkg::diff_t'(point_x_r);
    py = irht_pkg::diff_t'(point_y_r);
    ax = irht_pkg::diff_t'(ax_r);
    ay = irht_pkg::diff_t'(ay_r);
    bx = irht_pkg::diff_t'(bx_r);
    by = irht_pkg::diff_t'(by_r);
    x1 = irht_pkg::diff_t'(prev_vx_r);
    y1 = irht_pkg::diff_t'(prev_vy_r);
    if (kind_r == irht_pkg::KIND_CLOSE) begin
      x2 = irht_pkg::diff_t'(first_vx_r);
      y2 = irht_pkg::diff_t'(first_vy_r);
    end else begin
      x2 = ax;
      y2 = ay;
    end
    span      = (y1 <= py && y2 > py) || (y1 > py && y2 <= py);
    right_all = (px >= x1) && (px >= x2);
    left_all  = (px < x1) && (px < x2);
    dy = y2 - y1;
    ty = py - y1;
    if (dy < 0) begin
      dy = -dy;
      ty = -ty;
    end
    edge_active = !edge_forced_r && vertex_seen_r &&
                  (kind_r == irht_pkg::KIND_VERTEX || kind_r == irht_pkg::KIND_CLOSE);
    on_h = (y1 == y2) && (py == y1) &&
           ((px >= x1 && px <= x2) || (px <= x1 && px >= x2));
    force_set = edge_active && !span && on_h;

    fe_nxt             = '0;
    fe_nxt.valid       = in_v_r;
    fe_nxt.kind        = kind_r;
    fe_nxt.id          = id_r;
    fe_nxt.rect_hit    = ((px >= ax && px <= bx) || (px >= bx && px <= ax)) &&
                         ((py >= ay && py <= by) || (py >= by && py <= ay));
    fe_nxt.circ_ok     = !bx_r[irht_pkg::COORD_BITS-1];
    fe_nxt.close_live  = vertex_seen_r;
    fe_nxt.forced      = edge_forced_r || force_set;
    fe_nxt.edge_toggle = edge_active && span && right_all;
    fe_nxt.edge_mul    = edge_active && span && !right_all && !left_all;
    fe_nxt.radius      = bx_r;
    if (kind_r == irht_pkg::KIND_CIRCLE) begin
      fe_nxt.op_a = px - ax;
      fe_nxt.op_b = px - ax;
      fe_nxt.op_c = py - ay;
      fe_nxt.op_d = py - ay;
    end else begin
      fe_nxt.op_a = px - x1;
      fe_nxt.op_b = dy;
      fe_nxt.op_c = x2 - x1;
      fe_nxt.op_d = ty;
    end

    point_x_nxt     = point_x_r;
    point_y_nxt     = point_y_r;
    first_vx_nxt    = first_vx_r;
    first_vy_nxt    = first_vy_r;
    prev_vx_nxt     = prev_vx_r;
    prev_vy_nxt     = prev_vy_r;
    vertex_seen_nxt = vertex_seen_r;
    edge_forced_nxt = edge_forced_r;
    if (in_v_r) begin
      case (kind_r)
        irht_pkg::KIND_START: begin
          point_x_nxt     = ax_r;
          point_y_nxt     = ay_r;
          first_vx_nxt    = '0;
          first_vy_nxt    = '0;
          prev_vx_nxt     = '0;
          prev_vy_nxt     = '0;
          vertex_seen_nxt = 1'b0;
          edge_forced_nxt = 1'b0;
        end
        irht_pkg::KIND_VERTEX: begin
          if (!vertex_seen_r) begin
            first_vx_nxt    = ax_r;
            first_vy_nxt    = ay_r;
            vertex_seen_nxt = 1'b1;
          end else if (force_set) begin
            edge_forced_nxt = 1'b1;
          end
          prev_vx_nxt = ax_r;
          prev_vy_nxt = ay_r;
        end
        irht_pkg::KIND_CLOSE: begin
          vertex_seen_nxt = 1'b0;
          edge_forced_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_x_r     <= '0;
      point_y_r     <= '0;
      first_vx_r    <= '0;
      first_vy_r    <= '0;
      prev_vx_r     <= '0;
      prev_vy_r     <= '0;
      vertex_seen_r <= 1'b0;
      edge_forced_r <= 1'b0;
      fe_r.valid    <= 1'b0;
    end else if (en) begin
      point_x_r     <= point_x_nxt;
      point_y_r     <= point_y_nxt;
      first_vx_r    <= first_vx_nxt;
      first_vy_r    <= first_vy_nxt;
      prev_vx_r     <= prev_vx_nxt;
      prev_vy_r     <= prev_vy_nxt;
      vertex_seen_r <= vertex_seen_nxt;
      edge_forced_r <= edge_forced_nxt;
      fe_r          <= fe_nxt;
    end
  end

endmodule

>>> rtl/irht_mul.sv
module irht_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  irht_pkg::fe_t  fe_r,
  output irht_pkg::mp_t  mp_r
);

  irht_pkg::diff_t  a, b, c, d;
  irht_pkg::coord_t rad;
  irht_pkg::mp_t    mp_nxt;

  always_comb begin
    a   = fe_r.op_a;
    b   = fe_r.op_b;
    c   = fe_r.op_c;
    d   = fe_r.op_d;
    rad = fe_r.radius;
    mp_nxt             = '0;
    mp_nxt.valid       = fe_r.valid;
    mp_nxt.kind        = fe_r.kind;
    mp_nxt.id          = fe_r.id;
    mp_nxt.rect_hit    = fe_r.rect_hit;
    mp_nxt.circ_ok     = fe_r.circ_ok;
    mp_nxt.close_live  = fe_r.close_live;
    mp_nxt.forced      = fe_r.forced;
    mp_nxt.edge_toggle = fe_r.edge_toggle;
    mp_nxt.edge_mul    = fe_r.edge_mul;
    mp_nxt.p0          = irht_pkg::prod_t'(a) * irht_pkg::prod_t'(b);
    mp_nxt.p1          = irht_pkg::prod_t'(c) * irht_pkg::prod_t'(d);
    mp_nxt.rsq         = irht_pkg::prod_t'(rad) * irht_pkg::prod_t'(rad);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r.valid <= 1'b0;
    end else if (en) begin
      mp_r <= mp_nxt;
    end
  end

endmodule

>>> rtl/irht_back.sv
module irht_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  irht_pkg::mp_t  mp_r,
  input  logic           out_stall,
  output logic           out_valid,
  output logic           out_found,
  output irht_pkg::id_t  out_match_id
);

  logic          have_match_r, have_match_nxt, parity_r, parity_nxt;
  irht_pkg::id_t best_id_r, best_id_nxt;
  logic          out_valid_r, out_valid_nxt, out_found_r, out_found_nxt;
  irht_pkg::id_t out_id_r, out_id_nxt;

  irht_pkg::prod_t p0, p1, rsq;
  irht_pkg::sum_t  dsq;
  logic            edge_hit, circ_hit;

  always_comb begin
    p0       = mp_r.p0;
    p1       = mp_r.p1;
    rsq      = mp_r.rsq;
    dsq      = irht_pkg::sum_t'(p0) + irht_pkg::sum_t'(p1);
    edge_hit = mp_r.edge_toggle || (mp_r.edge_mul && (p0 >= p1));
    circ_hit = mp_r.circ_ok && (dsq <= irht_pkg::sum_t'(rsq));

    have_match_nxt = have_match_r;
    best_id_nxt    = best_id_r;
    parity_nxt     = parity_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_found_nxt  = out_found_r;
    out_id_nxt     = out_id_r;
    if (mp_r.valid && en) begin
      case (mp_r.kind)
        irht_pkg::KIND_START: begin
          have_match_nxt = 1'b0;
          best_id_nxt    = '0;
          parity_nxt     = 1'b0;
        end
        irht_pkg::KIND_DEFAULT: begin
          if (!have_match_r) begin
            have_match_nxt = 1'b1;
            best_id_nxt    = mp_r.id;
          end
        end
        irht_pkg::KIND_RECT: begin
          if (mp_r.rect_hit) begin
            have_match_nxt = 1'b1;
            best_id_nxt    = mp_r.id;
          end
        end
        irht_pkg::KIND_CIRCLE: begin
          if (circ_hit) begin
            have_match_nxt = 1'b1;
            best_id_nxt    = mp_r.id;
          end
        end
        irht_pkg::KIND_VERTEX: begin
          parity_nxt = parity_r ^ edge_hit;
        end
        irht_pkg::KIND_CLOSE: begin
          if (mp_r.close_live && ((parity_r ^ edge_hit) || mp_r.forced)) begin
            have_match_nxt = 1'b1;
            best_id_nxt    = mp_r.id;
          end
          parity_nxt = 1'b0;
        end
        irht_pkg::KIND_FINISH: begin
          out_valid_nxt = 1'b1;
          out_found_nxt = have_match_r;
          out_id_nxt    = have_match_r ? best_id_r : '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_match_r <= 1'b0;
      best_id_r    <= '0;
      parity_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      have_match_r <= have_match_nxt;
      best_id_r    <= best_id_nxt;
      parity_r     <= parity_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_id_r    <= out_id_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_found    = out_found_r;
  assign out_match_id = out_id_r;

endmodule

>>> rtl/irht_checker.sv
module irht_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_stall,
  input logic             out_valid,
  input logic             out_stall,
  input logic             out_found,
  input irht_pkg::id_t    out_match_id
);

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a stalled result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_found) && $stable(out_match_id)))
    else $error("stalled result changed");

  a_no_match_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_id == '0))
    else $error("match id nonzero without a match");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind image_region_hit_test_core irht_checker u_irht_checker (.*);

>>> test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]       KIND_UNUSED    = 3'd7;
  localparam irht_pkg::coord_t C_MAX          = {1'b0, {(irht_pkg::COORD_BITS-1){1'b1}}};
  localparam irht_pkg::coord_t C_MIN          = {1'b1, {(irht_pkg::COORD_BITS-1){1'b0}}};
  localparam int               ITEM_GOAL      = 550;
  localparam int               WATCHDOG_LIMIT = 5000;
  localparam int               DRAIN_CYCLES   = 8;

  typedef struct packed {
    logic [2:0]       kind;
    irht_pkg::coord_t ax;
    irht_pkg::coord_t ay;
    irht_pkg::coord_t bx;
    irht_pkg::coord_t by;
    irht_pkg::id_t    id;
    logic             typed;
    logic             exp_found;
    irht_pkg::id_t    exp_id;
  } rec_t;

  typedef struct packed {
    logic          found;
    irht_pkg::id_t id;
  } hit_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [2:0]       in_kind;
  irht_pkg::coord_t in_a_x;
  irht_pkg::coord_t in_a_y;
  irht_pkg::coord_t in_b_x;
  irht_pkg::coord_t in_b_y;
  irht_pkg::id_t    in_target_id;
  logic             out_valid;
  logic             out_stall;
  logic             out_found;
  irht_pkg::id_t    out_match_id;

  image_region_hit_test_core i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_a_x       (in_a_x),
    .in_a_y       (in_a_y),
    .in_b_x       (in_b_x),
    .in_b_y       (in_b_y),
    .in_target_id (in_target_id),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_found    (out_found),
    .out_match_id (out_match_id)
  );

  // query and polygon state of the hit predictor
  longint        pt_x, pt_y, first_x, first_y, prev_x, prev_y;
  bit            have_hit, vertex_seen, parity, edge_forced;
  irht_pkg::id_t best_id;

  hit_t   pending_hits[$];
  int     n_records;
  int     n_results;
  int     n_errors;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     idle_cycles;

  rec_t dir_tab [27] = '{
    '{irht_pkg::KIND_FINISH,  0,     0,     0,     0,     0,        1, 0, 0},
    '{irht_pkg::KIND_START,   0,     0,     0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_DEFAULT, 0,     0,     0,     0,     5,        0, 0, 0},
    '{irht_pkg::KIND_FINISH,  0,     0,     0,     0,     0,        1, 1, 5},
    '{irht_pkg::KIND_RECT,    C_MAX, C_MAX, C_MIN, C_MIN, 16'hFFFF, 0, 0, 0},
    '{irht_pkg::KIND_DEFAULT, 0,     0,     0,     0,     7,        0, 0, 0},
    '{irht_pkg::KIND_FINISH,  0,     0,     0,     0,     0,        1, 1, 16'hFFFF},
    '{irht_pkg::KIND_START,   C_MAX, C_MIN, 0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_CIRCLE,  C_MIN, C_MAX, C_MAX, 0,     1,        0, 0, 0},
    '{irht_pkg::KIND_CIRCLE,  C_MAX, C_MIN, -1,    0,     2,        0, 0, 0},
    '{irht_pkg::KIND_CIRCLE,  C_MAX, C_MIN, 0,     0,     3,        0, 0, 0},
    '{irht_pkg::KIND_FINISH,  0,     0,     0,     0,     0,        1, 1, 3},
    '{irht_pkg::KIND_START,   0,     0,     0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_VERTEX,  -256,  -256,  0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_RECT,    1000,  1000,  2000,  2000,  1,        0, 0, 0},
    '{irht_pkg::KIND_VERTEX,  256,   -256,  0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_VERTEX,  0,     256,   0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_CLOSE,   0,     0,     0,     0,     9,        0, 0, 0},
    '{irht_pkg::KIND_FINISH,  0,     0,     0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_VERTEX,  -512,  0,     0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_VERTEX,  512,   0,     0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_CLOSE,   0,     0,     0,     0,     10,       0, 0, 0},
    '{irht_pkg::KIND_CLOSE,   0,     0,     0,     0,     11,       0, 0, 0},
    '{irht_pkg::KIND_VERTEX,  0,     0,     0,     0,     0,        0, 0, 0},
    '{irht_pkg::KIND_CLOSE,   0,     0,     0,     0,     12,       0, 0, 0},
    '{KIND_UNUSED,            C_MIN, C_MIN, C_MIN, C_MIN, 16'hFFFF, 0, 0, 0},
    '{irht_pkg::KIND_FINISH,  0,     0,     0,     0,     0,        0, 0, 0}
  };

  initial clk = 1'b0;
  always #1ns clk = ~clk;

  function automatic void take_hit(irht_pkg::id_t id);
    have_hit = 1'b1;
    best_id  = id;
  endfunction

  // crossing-parity step for one polygon edge, exact cross-multiplication
  function automatic void cross_edge(longint x1, longint y1, longint x2, longint y2);
    longint dy, ty;
    if (edge_forced) return;
    if ((y1 <= pt_y && y2 > pt_y) || (y1 > pt_y && y2 <= pt_y)) begin
      if (pt_x >= x1 && pt_x >= x2) begin
        parity = !parity;
      end else if (!(pt_x < x1 && pt_x < x2)) begin
        dy = y2 - y1;
        ty = pt_y - y1;
        if (dy < 0) begin
          dy = -dy;
          ty = -ty;
        end
        if ((pt_x - x1) * dy >= (x2 - x1) * ty) parity = !parity;
      end
    end else if (y1 == y2 && pt_y == y1) begin
      if ((pt_x >= x1 && pt_x <= x2) || (pt_x <= x1 && pt_x >= x2)) edge_forced = 1'b1;
    end
  endfunction

  // applies one record to the hit state; returns 1 when it yields a result
  function automatic bit step_region(input rec_t r, output logic found,
                                     output irht_pkg::id_t id);
    longint ax, ay, bx, by, lx, hx, ly, hy, dx, dy;
    ax = $signed(r.ax);
    ay = $signed(r.ay);
    bx = $signed(r.bx);
    by = $signed(r.by);
    found = 1'b0;
    id = '0;
    case (r.kind)
      irht_pkg::KIND_START: begin
        {first_x, first_y, prev_x, prev_y} = '0;
        {have_hit, vertex_seen, parity, edge_forced} = '0;
        best_id = '0;
        pt_x = ax;
        pt_y = ay;
      end
      irht_pkg::KIND_DEFAULT: begin
        if (!have_hit) take_hit(r.id);
      end
      irht_pkg::KIND_RECT: begin
        lx = (ax < bx) ? ax : bx;
        hx = (ax > bx) ? ax : bx;
        ly = (ay < by) ? ay : by;
        hy = (ay > by) ? ay : by;
        if (pt_x >= lx && pt_x <= hx && pt_y >= ly && pt_y <= hy) take_hit(r.id);
      end
      irht_pkg::KIND_CIRCLE: begin
        dx = pt_x - ax;
        dy = pt_y - ay;
        if (bx >= 0 && dx * dx + dy * dy <= bx * bx) take_hit(r.id);
      end
      irht_pkg::KIND_VERTEX: begin
        if (!vertex_seen) begin
          first_x = ax;
          first_y = ay;
          vertex_seen = 1'b1;
        end else begin
          cross_edge(prev_x, prev_y, ax, ay);
        end
        prev_x = ax;
        prev_y = ay;
      end
      irht_pkg::KIND_CLOSE: begin
        if (vertex_seen) begin
          cross_edge(prev_x, prev_y, first_x, first_y);
          if (parity || edge_forced) take_hit(r.id);
        end
        {vertex_seen, parity, edge_forced} = '0;
      end
      irht_pkg::KIND_FINISH: begin
        found = have_hit;
        id = have_hit ? best_id : '0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic rec_t mk_rec(logic [2:0] kind, irht_pkg::coord_t ax,
                                  irht_pkg::coord_t ay, irht_pkg::coord_t bx,
                                  irht_pkg::coord_t by, irht_pkg::id_t id);
    rec_t r;
    r = '0;
    r.kind = kind;
    r.ax = ax;
    r.ay = ay;
    r.bx = bx;
    r.by = by;
    r.id = id;
    return r;
  endfunction

  function automatic irht_pkg::coord_t rnd_coord();
    return irht_pkg::coord_t'($urandom);
  endfunction

  function automatic irht_pkg::id_t rnd_id();
    return irht_pkg::id_t'($urandom);
  endfunction

  // mostly close to c, sometimes exactly c, an extreme or anything at all
  function automatic irht_pkg::coord_t near_coord(irht_pkg::coord_t c);
    case ($urandom_range(0, 9))
      0: return rnd_coord();
      1: return c;
      2: return $urandom_range(0, 1) ? C_MAX : C_MIN;
      default: return c + irht_pkg::coord_t'(int'($urandom_range(0, 4095)) - 2048);
    endcase
  endfunction

  // one transfer on the record channel, with random idle cycles ahead of it
  task automatic send(input rec_t r);
    logic          found;
    irht_pkg::id_t id;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= r.kind;
    in_a_x       <= r.ax;
    in_a_y       <= r.ay;
    in_b_x       <= r.bx;
    in_b_y       <= r.by;
    in_target_id <= r.id;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (r.kind != KIND_UNUSED) n_records++;
    if (step_region(r, found, id)) begin
      if (r.typed) pending_hits.push_back({r.exp_found, r.exp_id});
      else pending_hits.push_back({found, id});
    end
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_hits.size() != 0) @(negedge clk);
  endtask

  task automatic run_query();
    irht_pkg::coord_t px, py, vx, vy;
    px = near_coord('0);
    py = near_coord('0);
    send(mk_rec(irht_pkg::KIND_START, px, py, rnd_coord(), rnd_coord(), rnd_id()));
    repeat ($urandom_range(1, 8)) begin
      case ($urandom_range(0, 9))
        0: send(mk_rec(irht_pkg::KIND_DEFAULT, rnd_coord(), rnd_coord(), rnd_coord(),
                       rnd_coord(), rnd_id()));
        1, 2: send(mk_rec(irht_pkg::KIND_RECT, near_coord(px), near_coord(py),
                          near_coord(px), near_coord(py), rnd_id()));
        3, 4: send(mk_rec(irht_pkg::KIND_CIRCLE, near_coord(px), near_coord(py),
                          $urandom_range(0, 4) == 0
                            ? rnd_coord()
                            : irht_pkg::coord_t'($urandom_range(0, 3000)),
                          rnd_coord(), rnd_id()));
        5: send(mk_rec(irht_pkg::KIND_FINISH, rnd_coord(), rnd_coord(), rnd_coord(),
                       rnd_coord(), rnd_id()));
        default: begin
          vy = near_coord(py);
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 7) == 0)
              send(mk_rec(irht_pkg::KIND_RECT, near_coord(px), near_coord(py),
                          near_coord(px), near_coord(py), rnd_id()));
            vx = near_coord(px);
            // keep y now and then so horizontal edges show up
            if ($urandom_range(0, 4) != 0) vy = near_coord(py);
            send(mk_rec(irht_pkg::KIND_VERTEX, vx, vy, rnd_coord(), rnd_coord(), rnd_id()));
          end
          send(mk_rec(irht_pkg::KIND_CLOSE, rnd_coord(), rnd_coord(), rnd_coord(),
                      rnd_coord(), rnd_id()));
        end
      endcase
    end
    send(mk_rec(irht_pkg::KIND_FINISH, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(),
                rnd_id()));
  endtask

  task automatic run_noise();
    repeat ($urandom_range(3, 10))
      send(mk_rec(3'($urandom_range(0, 7)), rnd_coord(), rnd_coord(), rnd_coord(),
                  rnd_coord(), rnd_id()));
  endtask

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin : check_results
    hit_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (pending_hits.size() == 0) begin
        $error("unexpected result: found %0d, match_id %0d", out_found, out_match_id);
        n_errors++;
      end else begin
        want = pending_hits.pop_front();
        if (out_found !== want.found) begin
          $error("found: expected %0d, got %0d", want.found, out_found);
          n_errors++;
        end
        if (out_match_id !== want.id) begin
          $error("match_id: expected %0d, got %0d", want.id, out_match_id);
          n_errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("image_region_hit_test_core test failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_kind        = '0;
    in_a_x         = '0;
    in_a_y         = '0;
    in_b_x         = '0;
    in_b_y         = '0;
    in_target_id   = '0;
    out_stall      = 1'b0;
    n_records      = 0;
    n_results      = 0;
    n_errors       = 0;
    idle_cycles    = 0;
    send_idle_pct  = 29;
    recv_stall_pct = 82;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_tab[i]) send(dir_tab[i]);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct  = (ph == 0) ? 29 : (ph == 1) ? 82 : 0;
      recv_stall_pct = (ph == 0) ? 82 : (ph == 1) ? 29 : 0;
      while (n_records < (ph + 1) * ITEM_GOAL / 3) begin
        if ($urandom_range(0, 7) == 0) run_noise();
        else run_query();
      end
      // hold off the source until every result is back
      wait_for_results();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_hits.size() != 0) begin
      $error("%0d expected results never arrived", pending_hits.size());
      n_errors++;
    end
    $display("Covered %0d region records (directed shapes plus random queries and noise),",
             n_records);
    $display("%0d results checked under source-throttled, sink-throttled and full-rate flow",
             n_results);
    if (n_errors == 0) begin
      $display("image_region_hit_test_core test passed");
    end else begin
      $display("image_region_hit_test_core test failed");
    end
    $finish;
  end

endmodule
